// ===== hw/rtl/crct_pkg.sv =====
// ----------------------------------------------------------------------------
// crct_pkg
// Shared types, constants and the remainder generator for the CRC-32 block.
// ----------------------------------------------------------------------------
`default_nettype none

package crct_pkg;

  localparam int CRC_W         = 32;
  localparam int BYTE_W        = 8;
  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int FILL_CNT_W    = ADDR_W + 1;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

  // One access to the remainder table.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CRC_W-1:0]  wdata;
  } mem_req_t;

  // Reflected CRC-32 remainder of one byte value, eight shift steps.
  function automatic logic [CRC_W-1:0] crc_remainder(input logic [BYTE_W-1:0] v);
    logic [CRC_W-1:0] r;
    r = {{(CRC_W-BYTE_W){1'b0}}, v};
    for (int b = 0; b < BYTE_W; b++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crct_ram.sv =====
// ----------------------------------------------------------------------------
// crct_ram
// Single-port remainder table, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crct_ram
  import crct_pkg::*;
(
  input  wire logic             clk,
  input  wire mem_req_t         req,
  output logic      [CRC_W-1:0] rdata
);

  logic [CRC_W-1:0] mem [TABLE_ENTRIES];

  // Read data holds its value on cycles without a read.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/crct_fill.sv =====
// ----------------------------------------------------------------------------
// crct_fill
// Writes the remainder of every byte value into the table after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module crct_fill
  import crct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  output mem_req_t  req,
  output logic      table_ready
);

  logic [FILL_CNT_W-1:0] fill_cnt;

  assign table_ready = (fill_cnt == FILL_CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (!table_ready) begin
      fill_cnt <= fill_cnt + FILL_CNT_W'(1);
    end
  end

  always_comb begin
    req.en    = !table_ready;
    req.we    = 1'b1;
    req.addr  = fill_cnt[ADDR_W-1:0];
    req.wdata = crc_remainder(fill_cnt[ADDR_W-1:0]);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/crct_fold.sv =====
// ----------------------------------------------------------------------------
// crct_fold
// Byte fold engine, registered result: one lookup per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module crct_fold
  import crct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              table_ready,
  input  wire logic [CRC_W-1:0]  seed,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              func,
  input  wire logic [CRC_W-1:0]  data_word,
  input  wire logic              restart,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [CRC_W-1:0]  crc_value,
  output mem_req_t               req,
  input  wire logic [CRC_W-1:0]  rdata
);

  localparam int HI_W = CRC_W - BYTE_W;

  logic              pend;         // a lookup result is present on rdata
  logic [1:0]        rem;          // bytes still to fold after that lookup
  logic [HI_W-1:0]   crc_hi;       // crc >> 8 of the lookup in flight
  logic [HI_W-1:0]   bytes_sh;     // remaining bytes, next one on top
  logic [CRC_W-1:0]  running_crc;

  logic [CRC_W-1:0]  cur;
  logic [CRC_W-1:0]  base;
  logic [BYTE_W-1:0] first_byte;
  logic              out_free;
  logic              done;
  logic              step;
  logic              accept;
  logic              complete;

  assign cur        = pend ? ({{BYTE_W{1'b0}}, crc_hi} ^ rdata) : running_crc;
  assign base       = restart ? seed : cur;
  assign first_byte = func ? data_word[CRC_W-1 -: BYTE_W] : data_word[BYTE_W-1:0];
  assign out_free   = !out_valid || out_ready;
  assign done       = pend && (rem == 2'd0);
  assign step       = pend && (rem != 2'd0);
  assign complete   = done && out_free;
  assign in_ready   = table_ready && (!pend || complete);
  assign accept     = in_valid && in_ready;

  always_comb begin
    req.we    = 1'b0;
    req.wdata = '0;
    req.en    = accept || step;
    if (accept) begin
      req.addr = base[BYTE_W-1:0] ^ first_byte;
    end else begin
      req.addr = cur[BYTE_W-1:0] ^ bytes_sh[HI_W-1 -: BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 1'b0;
      out_valid   <= 1'b0;
      running_crc <= '0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (complete) begin
        pend <= 1'b0;
      end
      if (complete) begin
        running_crc <= cur;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem      <= func ? 2'd3 : 2'd0;
      crc_hi   <= base[CRC_W-1:BYTE_W];
      bytes_sh <= data_word[HI_W-1:0];
    end else if (step) begin
      rem      <= rem - 2'd1;
      crc_hi   <= cur[CRC_W-1:BYTE_W];
      bytes_sh <= {bytes_sh[HI_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
    if (complete) begin
      crc_value <= cur;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/crc32_table_update.sv =====
// ----------------------------------------------------------------------------
// crc32_table_update
// Reflected table-driven CRC-32 accumulator with a self-filled remainder table.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    func, data_word, restart
// out       source     out_valid / out_ready  crc_value
// cfg       sink       cfg_valid / cfg_ready  crc_seed
//
// After reset the table is filled with one entry per cycle for all 256 byte
// values, and in_ready stays low until the fill is done. Configuration writes
// are taken on every cycle, during the fill too.
// A byte word takes one lookup in the table RAM and a word in word mode takes
// four, since every lookup address depends on the previous lookup's data and
// the single-port RAM serves one lookup per cycle. The result is loaded into
// the output register once the final lookup's data is back from the RAM and
// the output register is free.
// A stalled output holds the finished result in its register while the next
// word is already accepted and its lookups run up to the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_table_update
  import crct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CRC_W-1:0]  crc_seed,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              func,
  input  wire logic [CRC_W-1:0]  data_word,
  input  wire logic              restart,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [CRC_W-1:0]  crc_value
);

  logic [CRC_W-1:0] seed;
  logic             table_ready;
  mem_req_t         fill_req;
  mem_req_t         fold_req;
  mem_req_t         ram_req;
  logic [CRC_W-1:0] rdata;

  // The seed register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid) begin
      seed <= crc_seed;
    end
  end

  crct_fill u_fill (
    .clk         (clk),
    .rst         (rst),
    .req         (fill_req),
    .table_ready (table_ready)
  );

  crct_fold u_fold (
    .clk         (clk),
    .rst         (rst),
    .table_ready (table_ready),
    .seed        (seed),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .data_word   (data_word),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .crc_value   (crc_value),
    .req         (fold_req),
    .rdata       (rdata)
  );

  // The fill owns the RAM port until it is done; the fold engine never
  // issues a lookup before then because in_ready is held low.
  assign ram_req = table_ready ? fold_req : fill_req;

  crct_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/crct_checker.sv =====
// ----------------------------------------------------------------------------
// crct_checker
// Port-level checks on the CRC-32 block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crct_checker
  import crct_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             func,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CRC_W-1:0] crc_value
);

  // No word is taken and no result shown right after reset: the table fills.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!in_ready && !out_valid))
    else $error("word accepted or result shown right after reset");

  // An accepted byte word sets out_valid via the RAM read and output registers.
  a_byte_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !func) |=> ##1 out_valid)
    else $error("byte word produced no result in time");

  // The seed register never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("seed write stalled");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(crc_value)))
    else $error("stalled result changed or dropped");

endmodule

bind crc32_table_update crct_checker u_crct_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .crc_value (crc_value)
);

`default_nettype wire
